@@ rtl/rldr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rldr_pkg;

    // field widths
    localparam int ADC_BITS      = 10;
    localparam int TIME_BITS     = 32;
    localparam int MS_BITS       = 16;
    localparam int KEY_BITS      = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [KEY_BITS-1:0] key_t;

    // key codes
    localparam key_t KEY_NONE   = 3'd0;
    localparam key_t KEY_RIGHT  = 3'd1;
    localparam key_t KEY_UP     = 3'd2;
    localparam key_t KEY_DOWN   = 3'd3;
    localparam key_t KEY_LEFT   = 3'd4;
    localparam key_t KEY_SELECT = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_RIGHT    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_UP       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_DOWN     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_LEFT     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_SELECT   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_MS  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_DELAY = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_RATE  = 3'd7;

    // register reset values
    localparam logic [ADC_BITS-1:0] THR_RIGHT_RST    = ADC_BITS'(50);
    localparam logic [ADC_BITS-1:0] THR_UP_RST       = ADC_BITS'(195);
    localparam logic [ADC_BITS-1:0] THR_DOWN_RST     = ADC_BITS'(380);
    localparam logic [ADC_BITS-1:0] THR_LEFT_RST     = ADC_BITS'(555);
    localparam logic [ADC_BITS-1:0] THR_SELECT_RST   = ADC_BITS'(790);
    localparam logic [MS_BITS-1:0]  DEBOUNCE_RST     = MS_BITS'(30);
    localparam logic [MS_BITS-1:0]  REPEAT_DELAY_RST = MS_BITS'(400);
    localparam logic [MS_BITS-1:0]  REPEAT_RATE_RST  = MS_BITS'(150);

    // ladder thresholds, in test order
    typedef struct packed {
        logic [ADC_BITS-1:0] right;
        logic [ADC_BITS-1:0] up;
        logic [ADC_BITS-1:0] down;
        logic [ADC_BITS-1:0] left;
        logic [ADC_BITS-1:0] select;
    } thr_t;

endpackage

`default_nettype wire

@@ rtl/rldr_classify.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rldr_classify (
    input  wire logic [rldr_pkg::ADC_BITS-1:0] sample,
    input  wire rldr_pkg::thr_t                thr,
    output rldr_pkg::key_t                     raw_key
);
    import rldr_pkg::*;

    // first threshold that holds wins, whatever order the registers are in
    always_comb begin
        if (sample < thr.right) begin
            raw_key = KEY_RIGHT;
        end else if (sample < thr.up) begin
            raw_key = KEY_UP;
        end else if (sample < thr.down) begin
            raw_key = KEY_DOWN;
        end else if (sample < thr.left) begin
            raw_key = KEY_LEFT;
        end else if (sample < thr.select) begin
            raw_key = KEY_SELECT;
        end else begin
            raw_key = KEY_NONE;
        end
    end

endmodule

`default_nettype wire

@@ rtl/resistor_ladder_key_debounce_repeat_unit.sv @@
// channel | ports                                   | dir
// --------+-----------------------------------------+-----
// sample  | s_valid s_ready s_adc_sample s_now_ms   | in
// result  | m_valid m_ready m_key_event m_held_key  | out
// config  | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// One sample beat per cycle while not stalled; a result is registered at each stage.
// Stage one decodes the ladder key, stage two runs the debounce/repeat update
// against the state and loads the result register.
// The whole pipeline stalls only while a result sits unaccepted (m_ready low).
// Reset restores the default thresholds and times and clears the key state.
// Config writes are always taken (cfg_ready is high).
`timescale 1ns / 1ps
`default_nettype none

module resistor_ladder_key_debounce_repeat_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // sample channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [rldr_pkg::ADC_BITS-1:0]      s_adc_sample,
    input  wire logic [rldr_pkg::TIME_BITS-1:0]     s_now_ms,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output rldr_pkg::key_t                          m_key_event,
    output rldr_pkg::key_t                          m_held_key,
    // config channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rldr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rldr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import rldr_pkg::*;

    // config registers
    thr_t               thr_reg;
    logic [MS_BITS-1:0] debounce_reg;
    logic [MS_BITS-1:0] repeat_delay_reg;
    logic [MS_BITS-1:0] repeat_rate_reg;

    // key state
    key_t                 stable_key_reg, stable_key_next;
    key_t                 prev_raw_reg, prev_raw_next;
    logic [TIME_BITS-1:0] change_time_reg, change_time_next;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next;

    // pipeline
    logic                 s1_valid_reg;
    key_t                 s1_raw_reg;
    logic [TIME_BITS-1:0] s1_now_reg;
    logic                 m_valid_reg;
    key_t                 event_reg, event_next;
    key_t                 held_reg;
    logic                 advance;
    key_t                 raw_key;

    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] since_deadline;
    logic                 settling;
    logic                 due;

    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    assign m_valid     = m_valid_reg;
    assign m_key_event = event_reg;
    assign m_held_key  = held_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.right    <= THR_RIGHT_RST;
            thr_reg.up       <= THR_UP_RST;
            thr_reg.down     <= THR_DOWN_RST;
            thr_reg.left     <= THR_LEFT_RST;
            thr_reg.select   <= THR_SELECT_RST;
            debounce_reg     <= DEBOUNCE_RST;
            repeat_delay_reg <= REPEAT_DELAY_RST;
            repeat_rate_reg  <= REPEAT_RATE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THR_RIGHT:    thr_reg.right    <= cfg_data[ADC_BITS-1:0];
                REG_THR_UP:       thr_reg.up       <= cfg_data[ADC_BITS-1:0];
                REG_THR_DOWN:     thr_reg.down     <= cfg_data[ADC_BITS-1:0];
                REG_THR_LEFT:     thr_reg.left     <= cfg_data[ADC_BITS-1:0];
                REG_THR_SELECT:   thr_reg.select   <= cfg_data[ADC_BITS-1:0];
                REG_DEBOUNCE_MS:  debounce_reg     <= cfg_data[MS_BITS-1:0];
                REG_REPEAT_DELAY: repeat_delay_reg <= cfg_data[MS_BITS-1:0];
                REG_REPEAT_RATE:  repeat_rate_reg  <= cfg_data[MS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage one: ladder decode
    rldr_classify u_classify (
        .sample  (s_adc_sample),
        .thr     (thr_reg),
        .raw_key (raw_key)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_valid) begin
            s1_raw_reg <= raw_key;
            s1_now_reg <= s_now_ms;
        end
    end

    // stage two: debounce and repeat update
    assign elapsed        = s1_now_reg - change_time_reg;
    assign since_deadline = s1_now_reg - deadline_reg;
    assign settling       = elapsed < TIME_BITS'(debounce_reg);
    assign due            = !since_deadline[TIME_BITS-1];

    always_comb begin
        stable_key_next  = stable_key_reg;
        prev_raw_next    = prev_raw_reg;
        change_time_next = change_time_reg;
        deadline_next    = deadline_reg;
        event_next       = KEY_NONE;
        if (s1_raw_reg != prev_raw_reg) begin
            // raw key moved: restart the window
            prev_raw_next    = s1_raw_reg;
            change_time_next = s1_now_reg;
        end else if (settling) begin
            // still inside the debounce window
        end else if (s1_raw_reg != stable_key_reg) begin
            stable_key_next = s1_raw_reg;
            if (s1_raw_reg != KEY_NONE) begin
                deadline_next = s1_now_reg + TIME_BITS'(repeat_delay_reg);
                event_next    = s1_raw_reg;
            end
        end else if ((stable_key_reg == KEY_UP || stable_key_reg == KEY_DOWN) && due) begin
            // auto-repeat of a held up or down key
            deadline_next = s1_now_reg + TIME_BITS'(repeat_rate_reg);
            event_next    = stable_key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_key_reg  <= KEY_NONE;
            prev_raw_reg    <= KEY_NONE;
            change_time_reg <= '0;
            deadline_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                stable_key_reg  <= stable_key_next;
                prev_raw_reg    <= prev_raw_next;
                change_time_reg <= change_time_next;
                deadline_reg    <= deadline_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            event_reg <= event_next;
            held_reg  <= stable_key_next;
        end
    end

`ifndef SYNTHESIS
    // any event reports the key that is held after the step
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (event_reg == KEY_NONE || event_reg == held_reg))
        else $error("key event differs from held key");

    // the stable key only ever takes the value of the settled raw key
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(stable_key_reg) |-> (stable_key_reg == prev_raw_reg))
        else $error("stable key changed to an unsettled value");

    // a stable key change happens only when a stage-two beat advances
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(stable_key_reg) |-> $past(advance && s1_valid_reg))
        else $error("key state changed without a beat");

    // a result held under backpressure stays in place
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(held_reg)))
        else $error("stalled result was lost");
`endif

endmodule

`default_nettype wire
